/* rtl/core/lcpa_pkg.sv */
package lcpa_pkg;

  // sample format, fixed by the item fields
  localparam int SAMPLE_WIDTH = 24;

  // configuration port
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH = 32;
  localparam int GAIN_WIDTH     = 16;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_LEFT  = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_RIGHT = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LFO_DEPTH  = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PHASE_STEP = 2'd3;

  localparam int ONE_Q15 = 32768;

  // shared multiplier: sample or sine magnitude times gain, depth or sine
  localparam int MUL_A_W = SAMPLE_WIDTH + 1;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int RND_W   = PROD_W - 15;

  // sine values in Q1.15, one sign bit over a 17 bit magnitude
  localparam int SINE_W = 18;

  // multiplier operand selection
  typedef logic [2:0] mul_sel_t;
  localparam mul_sel_t MUL_GL  = 3'd0;
  localparam mul_sel_t MUL_GR  = 3'd1;
  localparam mul_sel_t MUL_DEP = 3'd2;
  localparam mul_sel_t MUL_PR  = 3'd3;
  localparam mul_sel_t MUL_PL  = 3'd4;

  // sine table address source
  typedef logic [1:0] rom_sel_t;
  localparam rom_sel_t ROM_PHASE = 2'd0;
  localparam rom_sel_t ROM_ANG   = 2'd1;
  localparam rom_sel_t ROM_ANG_Q = 2'd2;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
  } in_item_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    rom_sel_t rom_sel;
    logic     st_l;
    logic     st_r;
    logic     st_s;
    logic     st_ang;
    logic     st_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lfo_act;
  } status_t;

  // pi/2 in Q30
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // quarter-wave sine entry k, Q1.15, Taylor series in Q30 through x^13
  function automatic logic [15:0] sine_entry(input int k, input int addr_bits);
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint r;
    x    = (HALF_PI_Q30 * longint'(k)) >>> addr_bits;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    // terms alternate in sign, each divided by (2n)(2n+1)
    term = ((term * x2) >>> 30) / 64'sd6;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 64'sd20;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 64'sd42;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 64'sd72;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 64'sd110;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 64'sd156;
    sum  = sum + term;
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum + 64'sd16384) >>> 15;
    if (r > longint'(ONE_Q15)) begin
      r = longint'(ONE_Q15);
    end
    return 16'(r);
  endfunction

endpackage

/* rtl/core/lcpa_sine_rom.sv */
module lcpa_sine_rom import lcpa_pkg::*; #(
  parameter int ADDR_BITS = 10
) (
  input  logic                 clk,
  input  logic [ADDR_BITS:0]   addr,
  output logic [15:0]          data
);

  localparam int TAB_N = 1 << ADDR_BITS;

  logic [15:0] tab [TAB_N+1];
  logic [15:0] data_r;

  // quarter-wave table, entries 0 through TAB_N
  for (genvar k = 0; k <= TAB_N; k++) begin : g_tab
    localparam logic [15:0] ENTRY = sine_entry(k, ADDR_BITS);
    assign tab[k] = ENTRY;
  end

  // registered read
  always_ff @(posedge clk) begin
    data_r <= tab[addr];
  end

  assign data = data_r;

endmodule

/* rtl/core/lcpa_ctrl.sv */
module lcpa_ctrl import lcpa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GL   = 4'd1;
  localparam logic [3:0] S_GR   = 4'd2;
  localparam logic [3:0] S_DEP  = 4'd3;
  localparam logic [3:0] S_ANG  = 4'd4;
  localparam logic [3:0] S_RDR  = 4'd5;
  localparam logic [3:0] S_RDL  = 4'd6;
  localparam logic [3:0] S_ML   = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // sequencing and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = MUL_GL;
    cmd.rom_sel = ROM_PHASE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_GL;
        end
      end
      S_GL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GL;
        state_nxt   = S_GR;
      end
      S_GR: begin
        cmd.st_l    = 1'b1;
        cmd.st_s    = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GR;
        state_nxt   = S_DEP;
      end
      S_DEP: begin
        cmd.st_r    = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DEP;
        state_nxt   = status.lfo_act ? S_ANG : S_FIN;
      end
      S_ANG: begin
        cmd.st_ang = 1'b1;
        state_nxt  = S_RDR;
      end
      S_RDR: begin
        cmd.rom_sel = ROM_ANG;
        state_nxt   = S_RDL;
      end
      S_RDL: begin
        cmd.rom_sel = ROM_ANG_Q;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PR;
        state_nxt   = S_ML;
      end
      S_ML: begin
        cmd.st_r    = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PL;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        // hold here until the output register can take the result
        if (out_free) begin
          cmd.st_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register occupancy
  always_comb begin
    if (cmd.st_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/core/lcpa_dp.sv */
module lcpa_dp import lcpa_pkg::*; #(
  parameter int PHASE_WIDTH          = 32,
  parameter int SINE_TABLE_ADDR_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cmd_t                              cmd,
  output status_t                           status,
  input  in_item_t                          in_data,
  output out_item_t                         out_data,
  input  logic                              cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]          cfg_idx,
  input  logic [CFG_DATA_WIDTH-1:0]         cfg_wdata,
  output logic [SINE_TABLE_ADDR_BITS:0]     rom_addr,
  input  logic [15:0]                       rom_data
);

  localparam int AB = SINE_TABLE_ADDR_BITS;
  localparam logic [AB:0] TAB_N = (AB+1)'(1 << AB);
  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((1 << (SAMPLE_WIDTH-1)) - 1);
  localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);
  localparam logic signed [RND_W-1:0] LFO_HI = RND_W'(ONE_Q15);
  localparam logic [31:0] ANG_BASE  = 32'h2000_0000;
  localparam logic [31:0] QUARTER   = 32'h4000_0000;

  // configuration registers
  logic [GAIN_WIDTH-1:0]  gain_l_r;
  logic [GAIN_WIDTH-1:0]  gain_r_r;
  logic [GAIN_WIDTH-1:0]  depth_r;
  logic [PHASE_WIDTH-1:0] step_r;

  // working registers
  logic [PHASE_WIDTH-1:0]     phase_r;
  sample_t                    x_l_r, x_r_r;
  sample_t                    l_r, r_r;
  logic [15:0]                s_mag_r;
  logic                       s_neg_r;
  logic [31:0]                ang_r;
  logic                       rom_neg_r;
  logic signed [PROD_W-1:0]   prod_r;
  out_item_t                  out_r;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [SINE_W-1:0]   rom_val;
  logic [PROD_W-1:0]          prod_rnd;
  logic signed [RND_W-1:0]    rnd;
  sample_t                    sat_val;
  logic [16:0]                lfo_mag;
  logic signed [SINE_W-1:0]   lfo_val;
  logic [31:0]                ang_nxt;
  logic [31:0]                turn;
  logic [AB-1:0]              tab_idx;

  assign status.lfo_act = (depth_r != '0) && (step_r != '0);

  // config writes from the register port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_l_r <= GAIN_WIDTH'(ONE_Q15);
      gain_r_r <= GAIN_WIDTH'(ONE_Q15);
      depth_r  <= '0;
      step_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_GAIN_LEFT:  gain_l_r <= cfg_wdata[GAIN_WIDTH-1:0];
        REG_GAIN_RIGHT: gain_r_r <= cfg_wdata[GAIN_WIDTH-1:0];
        REG_LFO_DEPTH:  depth_r  <= cfg_wdata[GAIN_WIDTH-1:0];
        REG_PHASE_STEP: step_r   <= cfg_wdata[PHASE_WIDTH-1:0];
      endcase
    end
  end

  // lfo phase accumulator, advances once per item while the lfo runs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cmd.st_ang) begin
      phase_r <= phase_r + step_r;
    end
  end

  // sine table address: quadrant from the top bits, mirrored in odd quadrants
  always_comb begin
    unique case (cmd.rom_sel)
      ROM_ANG:   turn = ang_r;
      ROM_ANG_Q: turn = ang_r + QUARTER;
      default:   turn = 32'(phase_r) << (32 - PHASE_WIDTH);
    endcase
    tab_idx  = turn[29 -: AB];
    rom_addr = turn[30] ? (TAB_N - {1'b0, tab_idx}) : {1'b0, tab_idx};
  end

  // sign of the word coming out of the table
  always_ff @(posedge clk) begin
    rom_neg_r <= turn[31];
  end

  assign rom_val = rom_neg_r ? -$signed({2'b00, rom_data}) : $signed({2'b00, rom_data});

  // shared multiplier operands
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_GR: begin
        mul_a = MUL_A_W'(x_r_r);
        mul_b = $signed({2'b00, gain_r_r});
      end
      MUL_DEP: begin
        mul_a = $signed({{(MUL_A_W-16){1'b0}}, s_mag_r});
        mul_b = $signed({2'b00, depth_r});
      end
      MUL_PR: begin
        mul_a = MUL_A_W'(r_r);
        mul_b = rom_val;
      end
      MUL_PL: begin
        mul_a = MUL_A_W'(l_r);
        mul_b = rom_val;
      end
      default: begin
        mul_a = MUL_A_W'(x_l_r);
        mul_b = $signed({2'b00, gain_l_r});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // round half up from Q.15, then saturate
  always_comb begin
    prod_rnd = prod_r + PROD_W'(16384);
    rnd      = prod_rnd[PROD_W-1:15];
    if (rnd > SAT_HI) begin
      sat_val = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (rnd < SAT_LO) begin
      sat_val = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      sat_val = rnd[SAMPLE_WIDTH-1:0];
    end
  end

  // lfo value clamped to one, signed by the phase sine, then pan angle
  always_comb begin
    lfo_mag = (rnd > LFO_HI) ? 17'(ONE_Q15) : rnd[16:0];
    lfo_val = s_neg_r ? -$signed({1'b0, lfo_mag}) : $signed({1'b0, lfo_mag});
    ang_nxt = ANG_BASE + {lfo_val, 14'b0};
  end

  // item and intermediate registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_l_r <= in_data.left_in;
      x_r_r <= in_data.right_in;
    end
    if (cmd.st_l) begin
      l_r <= sat_val;
    end
    if (cmd.st_r) begin
      r_r <= sat_val;
    end
    if (cmd.st_s) begin
      s_mag_r <= rom_data;
      s_neg_r <= rom_neg_r;
    end
    if (cmd.st_ang) begin
      ang_r <= ang_nxt;
    end
    if (cmd.st_out) begin
      out_r.left_out  <= status.lfo_act ? sat_val : l_r;
      out_r.right_out <= r_r;
    end
  end

  assign out_data = out_r;

endmodule

/* rtl/core/lfo_constant_power_autopan_top.sv */
// a new item is accepted only in idle, once the last one is stored; the lfo path
// adds the pan angle, two sine reads and two pan products, all put in sequence by
// the single shared multiplier and the one-port sine table
// the output register lets the next item start while a result waits
// reset: synchronous active-low rst_n restores gains to 1.0, depth and phase step
// to zero and the lfo phase to zero; the sine table needs no clearing pass
module lfo_constant_power_autopan_top import lcpa_pkg::*; #(
  parameter int PHASE_WIDTH          = 32,
  parameter int SINE_TABLE_ADDR_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_item_t                 out_data,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_idx,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata
);

  cmd_t                          cmd;
  status_t                       status;
  logic [SINE_TABLE_ADDR_BITS:0] rom_addr;
  logic [15:0]                   rom_data;

  // sequencer
  lcpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic, config and phase
  lcpa_dp #(
    .PHASE_WIDTH          (PHASE_WIDTH),
    .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .rom_addr  (rom_addr),
    .rom_data  (rom_data)
  );

  // quarter-wave sine table
  lcpa_sine_rom #(
    .ADDR_BITS (SINE_TABLE_ADDR_BITS)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

`ifndef NO_ASSERTIONS
  // the sequencer leaves idle right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice without finishing the item");

  // a result is only written into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.st_out |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  // a written result is presented on the next cycle
  a_out_after_store: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.st_out |=> out_valid)
    else $error("stored result not presented");

  // the phase only moves on the lfo path
  a_ang_only_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.st_ang |-> status.lfo_act)
    else $error("phase advanced with the lfo off");
`endif

endmodule
